@@ sv/mmvf_pkg.sv @@
`timescale 1ns / 1ps

package mmvf_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int CHANNEL_W  = 1;
    localparam int COUNT_W    = 8;
    localparam int GAIN_W     = 16;
    localparam int SUM_W      = 20;
    localparam int RESULT_W   = 20;
    localparam int FRAC_W     = 8;
    localparam int SCALE_W    = 12;
    localparam int PROD_W     = SUM_W + GAIN_W;
    localparam int NUM_W      = PROD_W + SCALE_W;
    localparam int DVS_W      = SUM_W + FRAC_W;
    localparam int STEP_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int CHANNEL_COUNT_DEF = 2;

    localparam logic [SCALE_W-1:0]   MV_FULL_SCALE = 12'd3300;
    localparam logic [STEP_W-1:0]    MEAN_STEPS    = 6'(SUM_W + FRAC_W);
    localparam logic [STEP_W-1:0]    MV_STEPS      = 6'(NUM_W);

    localparam logic [CFG_IDX_W-1:0] REG_SELECTED_CHANNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEDIAN_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN             = 2'd2;

    localparam logic [COUNT_W-1:0]   MEDIAN_COUNT_RST = 8'd1;
    localparam logic [GAIN_W-1:0]    GAIN_RST         = 16'd256;

endpackage

@@ sv/median3_mean_voltage_filter.sv @@
`timescale 1ns / 1ps
// an item that completes no result is absorbed in the cycle it is accepted
// an item that completes a result raises m_tvalid after it has passed the gain and scale
// multiply states, 28 steps of the shared restoring divider for the mean,
// 48 steps of the same divider for millivolts, and the output load state
// throughput: one item a cycle in idle; s_tready low while busy, longer if m_tready holds off
// aresetn is synchronous: it clears the group, the accumulation and sets registers to defaults
module median3_mean_voltage_filter
    import mmvf_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // sample [11:0]
    input  logic [CHANNEL_W-1:0]  s_tuser,   // channel [0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,   // mean_q8 [19:0], millivolts [39:20]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GAIN,
        ST_MUL_SCALE,
        ST_DIV_MEAN,
        ST_DIV_MV,
        ST_OUT_WAIT
    } state_t;

    state_t state_reg, state_next;

    logic [CHANNEL_W-1:0] sel_ch_reg, sel_ch_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [GAIN_W-1:0]    gain_reg, gain_next;

    logic [SAMPLE_W-1:0]  held_reg [2];
    logic [SAMPLE_W-1:0]  held_next [2];
    logic [1:0]           pos_reg, pos_next;
    logic [COUNT_W-1:0]   taken_reg, taken_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;

    logic [SUM_W-1:0]     sum_w_reg, sum_w_next;
    logic [COUNT_W-1:0]   div_w_reg, div_w_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [NUM_W-1:0]     acc_reg, acc_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [STEP_W-1:0]    cnt_reg, cnt_next;
    logic [RESULT_W-1:0]  mean_reg, mean_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [39:0]          m_tdata_reg, m_tdata_next;

    logic [SAMPLE_W-1:0]  smp;
    logic                 ch_hit;
    logic [SAMPLE_W-1:0]  lo_ab, hi_ab, lo_hc, med;
    logic [SUM_W-1:0]     sum_new;
    logic [COUNT_W-1:0]   taken_new, need;
    logic [DVS_W:0]       rem_sh, rem_dif;
    logic                 ge;
    logic [NUM_W-1:0]     acc_step;
    logic [DVS_W-1:0]     rem_step;
    logic [SUM_W-1:0]     div_scaled;

    assign smp       = s_tdata[SAMPLE_W-1:0];
    assign ch_hit    = (s_tuser == sel_ch_reg) && (32'(s_tuser) < CHANNEL_COUNT);
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // median network
    assign lo_ab   = (held_reg[0] < held_reg[1]) ? held_reg[0] : held_reg[1];
    assign hi_ab   = (held_reg[0] > held_reg[1]) ? held_reg[0] : held_reg[1];
    assign lo_hc   = (hi_ab < smp) ? hi_ab : smp;
    assign med     = (lo_ab > lo_hc) ? lo_ab : lo_hc;
    assign sum_new   = sum_reg + SUM_W'(med);
    assign taken_new = taken_reg + 8'd1;
    assign need      = (count_reg == '0) ? 8'd1 : count_reg;

    // shared restoring divider step
    assign rem_sh   = {rem_reg, acc_reg[NUM_W-1]};
    assign rem_dif  = rem_sh - {1'b0, dvs_reg};
    assign ge       = (rem_sh >= {1'b0, dvs_reg});
    assign rem_step = ge ? rem_dif[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    assign acc_step = {acc_reg[NUM_W-2:0], ge};

    // count * 4095
    assign div_scaled = (SUM_W'(div_w_reg) << SAMPLE_W) - SUM_W'(div_w_reg);

    always_comb begin
        state_next    = state_reg;
        sel_ch_next   = sel_ch_reg;
        count_next    = count_reg;
        gain_next     = gain_reg;
        held_next     = held_reg;
        pos_next      = pos_reg;
        taken_next    = taken_reg;
        sum_next      = sum_reg;
        sum_w_next    = sum_w_reg;
        div_w_next    = div_w_reg;
        prod_next     = prod_reg;
        num_next      = num_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        dvs_next      = dvs_reg;
        cnt_next      = cnt_reg;
        mean_next     = mean_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (cfg_valid) begin
            case (cfg_index)
                REG_SELECTED_CHANNEL: sel_ch_next = cfg_data[CHANNEL_W-1:0];
                REG_MEDIAN_COUNT:     count_next  = cfg_data[COUNT_W-1:0];
                REG_GAIN:             gain_next   = cfg_data[GAIN_W-1:0];
                default:              ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && ch_hit) begin
                    if (pos_reg < 2'd2) begin
                        held_next[pos_reg[0]] = smp;
                        pos_next = pos_reg + 2'd1;
                    end else begin
                        pos_next = '0;
                        if (taken_new >= need) begin
                            sum_w_next = sum_new;
                            div_w_next = (taken_new == '0) ? 8'd1 : taken_new;
                            sum_next   = '0;
                            taken_next = '0;
                            state_next = ST_MUL_GAIN;
                        end else begin
                            sum_next   = sum_new;
                            taken_next = taken_new;
                        end
                    end
                end
            end
            ST_MUL_GAIN: begin
                prod_next  = PROD_W'(sum_w_reg) * PROD_W'(gain_reg);
                state_next = ST_MUL_SCALE;
            end
            ST_MUL_SCALE: begin
                num_next   = NUM_W'(prod_reg) * NUM_W'(MV_FULL_SCALE);
                acc_next   = {sum_w_reg, {(NUM_W-SUM_W){1'b0}}};
                rem_next   = '0;
                dvs_next   = DVS_W'(div_w_reg);
                cnt_next   = MEAN_STEPS;
                state_next = ST_DIV_MEAN;
            end
            ST_DIV_MEAN: begin
                acc_next = acc_step;
                rem_next = rem_step;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    mean_next  = acc_step[RESULT_W-1:0];
                    acc_next   = num_reg;
                    rem_next   = '0;
                    dvs_next   = {div_scaled, {FRAC_W{1'b0}}};
                    cnt_next   = MV_STEPS;
                    state_next = ST_DIV_MV;
                end
            end
            ST_DIV_MV: begin
                acc_next = acc_step;
                rem_next = rem_step;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    state_next = ST_OUT_WAIT;
                end
            end
            ST_OUT_WAIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {acc_reg[RESULT_W-1:0], mean_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            sel_ch_reg   <= '0;
            count_reg    <= MEDIAN_COUNT_RST;
            gain_reg     <= GAIN_RST;
            held_reg[0]  <= '0;
            held_reg[1]  <= '0;
            pos_reg      <= '0;
            taken_reg    <= '0;
            sum_reg      <= '0;
            sum_w_reg    <= '0;
            div_w_reg    <= '0;
            prod_reg     <= '0;
            num_reg      <= '0;
            acc_reg      <= '0;
            rem_reg      <= '0;
            dvs_reg      <= '0;
            cnt_reg      <= '0;
            mean_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            sel_ch_reg   <= sel_ch_next;
            count_reg    <= count_next;
            gain_reg     <= gain_next;
            held_reg     <= held_next;
            pos_reg      <= pos_next;
            taken_reg    <= taken_next;
            sum_reg      <= sum_next;
            sum_w_reg    <= sum_w_next;
            div_w_reg    <= div_w_next;
            prod_reg     <= prod_next;
            num_reg      <= num_next;
            acc_reg      <= acc_next;
            rem_reg      <= rem_next;
            dvs_reg      <= dvs_next;
            cnt_reg      <= cnt_next;
            mean_reg     <= mean_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    a_group_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg != 2'd3)
        else $error("group position out of range");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_MEAN || state_reg == ST_DIV_MV) |-> (dvs_reg != '0 && cnt_reg != '0))
        else $error("divider running with zero divisor or step count");

    a_accum_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL_GAIN) |-> (taken_reg == '0 && sum_reg == '0 && div_w_reg != '0))
        else $error("accumulation not cleared on result");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_OUT_WAIT))
        else $error("result raised outside output load");

    a_busy_no_group_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && $past(state_reg != ST_IDLE)) |-> $stable(pos_reg))
        else $error("group changed while busy");

endmodule
